// ----- rtl/core/bertlv_pkg.sv -----
// Shared types, codes and helpers for the BER primitive TLV encoder.
package bertlv_pkg;

  localparam int TAG_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH   = 2;
  localparam int TAG_FIELD_BYTES = 4;

  localparam logic [2:0] CMD_INTEGER    = 3'd0;
  localparam logic [2:0] CMD_ENUMERATED = 3'd1;
  localparam logic [2:0] CMD_BOOLEAN    = 3'd2;
  localparam logic [2:0] CMD_NULL       = 3'd3;
  localparam logic [2:0] CMD_OCTET_HDR  = 3'd4;
  localparam logic [2:0] CMD_BIT_HDR    = 3'd5;
  localparam logic [2:0] CMD_PAYLOAD    = 3'd6;
  localparam logic [2:0] CMD_NONE       = 3'd7;

  localparam logic [1:0] SEG_TAG  = 2'd0;
  localparam logic [1:0] SEG_LEN  = 2'd1;
  localparam logic [1:0] SEG_CONT = 2'd2;

  localparam logic [7:0]  LEN_LONG      = 8'h80;
  localparam logic [31:0] LEN_SHORT_MAX = 32'd127;
  localparam logic [7:0]  BOOL_TRUE     = 8'hFF;
  localparam logic [7:0]  BOOL_FALSE    = 8'h00;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        use_default_tag;
    logic [31:0] tag_value;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [TAG_FIELD_BYTES-1:0][7:0] tag;
    logic [2:0]                      tag_cnt;
    logic [4:0][7:0]                 len_seg;
    logic [2:0]                      len_cnt;
    logic [3:0][7:0]                 cont;
    logic [2:0]                      cont_cnt;
  } desc_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic emit_last;
  } back_stat_t;

  function automatic logic [7:0] default_tag(input logic [2:0] cmd);
    logic [7:0] t;
    unique case (cmd)
      CMD_INTEGER:    t = 8'h02;
      CMD_ENUMERATED: t = 8'h0A;
      CMD_BOOLEAN:    t = 8'h01;
      CMD_NULL:       t = 8'h05;
      CMD_OCTET_HDR:  t = 8'h04;
      default:        t = 8'h03;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/core/ber_primitive_tlv_encoder_top.sv -----
// Top level of the BER primitive TLV encoder.
// Each accepted command produces its BER bytes on the enc channel, one byte per cycle while
// enc_stall does not hold it, the final byte of the command flagged by last. A command has
// tag bytes (1 to TAG_BYTES, at most 4), length bytes (0 to 5) and content bytes
// (0 to 4), so 1 to 10 bytes with four tag bytes; a payload command produces one byte and
// the unused command code 7 is absorbed with no byte. Commands are classified as they enter
// and wait in a DEPTH-entry queue, so the command side keeps accepting until the queue holds
// DEPTH commands, and while one is queued the next command's first byte follows the previous
// command's last byte with no gap. Sustained, commands are accepted only as fast as the
// serializer drains their bytes.
module ber_primitive_tlv_encoder_top #(
  parameter int TAG_BYTES = bertlv_pkg::TAG_BYTES_DEF,
  parameter int DEPTH     = bertlv_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  bertlv_pkg::in_t  cmd_item,
  output logic             enc_valid,
  input  logic             enc_stall,
  output bertlv_pkg::out_t enc_item
);
  import bertlv_pkg::*;

  logic                       push;
  logic                       pop;
  desc_t                      wr_desc;
  desc_t                      rd_desc;
  logic                       q_valid;
  logic                       q_full;
  logic [$clog2(DEPTH+1)-1:0] q_count;
  back_stat_t                 stat;

  bertlv_front #(
    .TAG_BYTES(TAG_BYTES)
  ) u_front (
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_item (cmd_item),
    .q_full   (q_full),
    .push     (push),
    .desc     (wr_desc)
  );

  bertlv_queue #(
    .DEPTH(DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(wr_desc),
    .pop    (pop),
    .rd_data(rd_desc),
    .q_valid(q_valid),
    .q_full (q_full),
    .count  (q_count)
  );

  bertlv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (rd_desc),
    .pop      (pop),
    .enc_valid(enc_valid),
    .enc_stall(enc_stall),
    .enc_item (enc_item),
    .stat     (stat)
  );

  a_cmd_held: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd_item.cmd != CMD_NONE) |=> (q_count != '0 || stat.busy))
    else $error("accepted command was lost");

  a_mid_item_busy: assert property (@(posedge clk) disable iff (rst)
    (stat.emit && !stat.emit_last) |=> stat.busy)
    else $error("serializer went idle inside an item");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    stat.emit |=> enc_valid)
    else $error("emitted byte not presented");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($bits(q_count))'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- rtl/core/bertlv_front.sv -----
// Front end: accepts element commands and turns them into byte segment descriptors.
module bertlv_front #(
  parameter int TAG_BYTES = bertlv_pkg::TAG_BYTES_DEF
) (
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  bertlv_pkg::in_t   cmd_item,
  input  logic              q_full,
  output logic              push,
  output bertlv_pkg::desc_t desc
);
  import bertlv_pkg::*;

  localparam int KEPT = (TAG_BYTES < TAG_FIELD_BYTES) ? TAG_BYTES : TAG_FIELD_BYTES;

  logic [TAG_FIELD_BYTES-1:0][7:0] tag;
  logic [2:0]  tag_cnt;
  logic [2:0]  icnt;
  logic [2:0]  nlen;
  logic [31:0] len;
  logic [32:0] bit_sum;
  logic [2:0]  unused_bits;

  assign cmd_stall = q_full;
  assign push      = cmd_valid && !q_full && (cmd_item.cmd != CMD_NONE);

  always_comb begin
    tag = cmd_item.use_default_tag ? {24'h0, default_tag(cmd_item.cmd)} : cmd_item.tag_value;
    for (int i = 0; i < TAG_FIELD_BYTES; i++) begin
      if (i >= KEPT) begin
        tag[i] = 8'h00;
      end
    end
    tag_cnt = 3'd1;
    for (int i = 1; i < TAG_FIELD_BYTES; i++) begin
      if (tag[i] != 8'h00) begin
        tag_cnt = 3'(i + 1);
      end
    end

    if (cmd_item.value[31:23] != {9{cmd_item.value[31]}}) begin
      icnt = 3'd4;
    end else if (cmd_item.value[23:15] != {9{cmd_item.value[31]}}) begin
      icnt = 3'd3;
    end else if (cmd_item.value[15:7] != {9{cmd_item.value[31]}}) begin
      icnt = 3'd2;
    end else begin
      icnt = 3'd1;
    end

    bit_sum     = {1'b0, cmd_item.value} + 33'd7;
    unused_bits = 3'd0 - cmd_item.value[2:0];

    desc.cont     = '0;
    desc.cont_cnt = 3'd0;
    unique case (cmd_item.cmd)
      CMD_INTEGER, CMD_ENUMERATED: begin
        len           = {29'h0, icnt};
        desc.cont     = cmd_item.value;
        desc.cont_cnt = icnt;
      end
      CMD_BOOLEAN: begin
        len           = 32'd1;
        desc.cont     = {24'h0, (cmd_item.value != 32'h0) ? BOOL_TRUE : BOOL_FALSE};
        desc.cont_cnt = 3'd1;
      end
      CMD_NULL: begin
        len = 32'd0;
      end
      CMD_OCTET_HDR: begin
        len = cmd_item.value;
      end
      CMD_BIT_HDR: begin
        len           = {2'b00, bit_sum[32:3]} + 32'd1;
        desc.cont     = {29'h0, unused_bits};
        desc.cont_cnt = 3'd1;
      end
      default: begin
        len = 32'd0;
      end
    endcase

    if (len[31:24] != 8'h0) begin
      nlen = 3'd4;
    end else if (len[23:16] != 8'h0) begin
      nlen = 3'd3;
    end else if (len[15:8] != 8'h0) begin
      nlen = 3'd2;
    end else begin
      nlen = 3'd1;
    end

    if (len <= LEN_SHORT_MAX) begin
      desc.len_seg = {32'h0, len[7:0]};
      desc.len_cnt = 3'd1;
    end else begin
      unique case (nlen)
        3'd1:    desc.len_seg = {24'h0, LEN_LONG | 8'h01, len[7:0]};
        3'd2:    desc.len_seg = {16'h0, LEN_LONG | 8'h02, len[15:0]};
        3'd3:    desc.len_seg = {8'h0, LEN_LONG | 8'h03, len[23:0]};
        default: desc.len_seg = {LEN_LONG | 8'h04, len};
      endcase
      desc.len_cnt = nlen + 3'd1;
    end

    desc.tag     = tag;
    desc.tag_cnt = tag_cnt;
    if (cmd_item.cmd == CMD_PAYLOAD) begin
      desc.tag      = {24'h0, cmd_item.value[7:0]};
      desc.tag_cnt  = 3'd1;
      desc.len_cnt  = 3'd0;
      desc.cont_cnt = 3'd0;
    end
  end

endmodule

// ----- rtl/core/bertlv_queue.sv -----
// Short descriptor queue between the front end and the serializer.
module bertlv_queue #(
  parameter int DEPTH = bertlv_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bertlv_pkg::desc_t          wr_data,
  input  logic                       pop,
  output bertlv_pkg::desc_t          rd_data,
  output logic                       q_valid,
  output logic                       q_full,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import bertlv_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  assign q_valid = count != '0;
  assign q_full  = count == CW'(DEPTH);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/bertlv_back.sv -----
// Serializer: walks tag, length and content segments, emitting one byte per cycle unless stalled.
module bertlv_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  bertlv_pkg::desc_t      q_data,
  output logic                   pop,
  output logic                   enc_valid,
  input  logic                   enc_stall,
  output bertlv_pkg::out_t       enc_item,
  output bertlv_pkg::back_stat_t stat
);
  import bertlv_pkg::*;

  logic       busy;
  desc_t      cur;
  logic [1:0] seg;
  logic [2:0] idx;
  logic       adv;
  logic       is_last;
  logic [7:0] cur_byte;
  logic [7:0] len_byte;

  always_comb begin
    unique case (idx)
      3'd0:    len_byte = cur.len_seg[0];
      3'd1:    len_byte = cur.len_seg[1];
      3'd2:    len_byte = cur.len_seg[2];
      3'd3:    len_byte = cur.len_seg[3];
      3'd4:    len_byte = cur.len_seg[4];
      default: len_byte = 8'h00;
    endcase
    unique case (seg)
      SEG_TAG:  cur_byte = cur.tag[idx[1:0]];
      SEG_LEN:  cur_byte = len_byte;
      SEG_CONT: cur_byte = cur.cont[idx[1:0]];
      default:  cur_byte = 8'h00;
    endcase
    is_last = (idx == 3'd0) &&
              ((seg == SEG_TAG && cur.len_cnt == 3'd0) ||
               (seg == SEG_LEN && cur.cont_cnt == 3'd0) ||
               (seg == SEG_CONT));
  end

  assign adv = busy && (!enc_valid || !enc_stall);
  assign pop = q_valid && (!busy || (adv && is_last));

  assign stat.busy      = busy;
  assign stat.emit      = adv;
  assign stat.emit_last = adv && is_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (adv) begin
      enc_item.out_byte <= cur_byte;
      enc_item.last     <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      seg       <= SEG_TAG;
      idx       <= 3'd0;
      enc_valid <= 1'b0;
    end else begin
      if (adv) begin
        enc_valid <= 1'b1;
      end else if (!enc_stall) begin
        enc_valid <= 1'b0;
      end

      if (pop) begin
        busy <= 1'b1;
        seg  <= SEG_TAG;
        idx  <= q_data.tag_cnt - 3'd1;
      end else if (adv) begin
        if (is_last) begin
          busy <= 1'b0;
        end else if (idx != 3'd0) begin
          idx <= idx - 3'd1;
        end else if (seg == SEG_TAG) begin
          seg <= SEG_LEN;
          idx <= cur.len_cnt - 3'd1;
        end else begin
          seg <= SEG_CONT;
          idx <= cur.cont_cnt - 3'd1;
        end
      end
    end
  end

endmodule
